// ===== sv/tsr_pkg.sv =====
package tsr_pkg;

    localparam int DEV_W  = 8;
    localparam int TIME_W = 32;
    localparam int CNT_O_W = 5;

    // APB byte addresses of the configuration registers
    localparam logic [3:0] ADDR_CHANNEL_ID   = 4'h0;
    localparam logic [3:0] ADDR_MAX_DEVICES  = 4'h4;
    localparam logic [3:0] ADDR_TIMEOUT_MS   = 4'h8;
    localparam logic [3:0] ADDR_BROADCAST_ID = 4'hC;

    localparam logic [7:0]  RST_CHANNEL_ID   = 8'd0;
    localparam logic [4:0]  RST_MAX_DEVICES  = 5'd16;
    localparam logic [31:0] RST_TIMEOUT_MS   = 32'd30000;
    localparam logic [7:0]  RST_BROADCAST_ID = 8'hFF;

    localparam logic [7:0] REJECT_SLOT = 8'hFF;

    // shared unit operations
    localparam logic OP_MATCH = 1'b0;
    localparam logic OP_AGE   = 1'b1;

    typedef struct packed {
        logic [7:0]  channel_id;
        logic [4:0]  max_devices;
        logic [31:0] timeout_ms;
        logic [7:0]  broadcast_id;
    } tsr_cfg_t;

    typedef struct packed {
        logic              op;
        logic [DEV_W-1:0]  key_a;
        logic [DEV_W-1:0]  key_b;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] seen;
        logic [TIME_W-1:0] timeout;
    } tsr_alu_in_t;

endpackage

// ===== sv/tsr_if.sv =====
interface tsr_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  dev_id;
    logic        is_join;
    logic [31:0] now_ms;

    modport source (output valid, output req_type, output dev_id, output is_join,
                    output now_ms, input ready);
    modport sink   (input valid, input req_type, input dev_id, input is_join,
                    input now_ms, output ready);
endinterface

interface tsr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] target_dev;
    logic [7:0] assign_channel;
    logic [7:0] slot_index;
    logic [4:0] slot_total;
    logic [7:0] map_version;
    logic       rejected;
    logic       last;

    modport source (output valid, output target_dev, output assign_channel,
                    output slot_index, output slot_total, output map_version,
                    output rejected, output last, input ready);
    modport sink   (input valid, input target_dev, input assign_channel,
                    input slot_index, input slot_total, input map_version,
                    input rejected, input last, output ready);
endinterface

// ===== sv/tsr_ram.sv =====
module tsr_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tsr_alu.sv =====
module tsr_alu (
    input  tsr_pkg::tsr_alu_in_t alu_in,
    output logic                 hit
);
    logic [tsr_pkg::TIME_W-1:0] age;

    // wrapping age, so a counter rollover between frames is harmless
    assign age = alu_in.now - alu_in.seen;

    always_comb
    begin
        case (alu_in.op)
            tsr_pkg::OP_MATCH: hit = (alu_in.key_a == alu_in.key_b);
            tsr_pkg::OP_AGE:   hit = (age > alu_in.timeout);
            default:           hit = 1'b0;
        endcase
    end

endmodule

// ===== sv/tsr_ctrl.sv =====
module tsr_ctrl #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tsr_pkg::tsr_cfg_t cfg,
    tsr_req_if.sink           req,
    tsr_res_if.source         res
);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = tsr_pkg::DEV_W + tsr_pkg::TIME_W;
    localparam logic [4:0] DEPTH_LIM = 5'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_EXP     = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_LD = 3'd4;
    localparam logic [2:0] ST_REJ     = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             changed_reg, changed_next;
    logic [7:0]       version_reg, version_next;
    logic [4:0]       slots_reg, slots_next;
    logic [7:0]       dev_reg, dev_next;
    logic             join_reg, join_next;
    logic [31:0]      now_reg, now_next;

    logic             out_vld_reg, out_vld_next;
    logic [7:0]       out_dev_reg, out_dev_next;
    logic [7:0]       out_chan_reg, out_chan_next;
    logic [7:0]       out_slot_reg, out_slot_next;
    logic [4:0]       out_total_reg, out_total_next;
    logic [7:0]       out_ver_reg, out_ver_next;
    logic             out_rej_reg, out_rej_next;
    logic             out_last_reg, out_last_next;

    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [ENT_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [ENT_W-1:0] ram_rd_data;

    tsr_pkg::tsr_alu_in_t alu_in;
    logic                 alu_hit;

    logic             out_free;
    logic             issue;
    logic             walk_done;
    logic [4:0]       join_limit;
    logic             emit_go;
    logic [CNT_W-1:0] emit_cnt;
    logic             emit_last;

    tsr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        alu_in.op      = (state_reg == ST_EXP) ? tsr_pkg::OP_AGE : tsr_pkg::OP_MATCH;
        alu_in.key_a   = ram_rd_data[ENT_W-1:tsr_pkg::TIME_W];
        alu_in.key_b   = dev_reg;
        alu_in.now     = now_reg;
        alu_in.seen    = ram_rd_data[tsr_pkg::TIME_W-1:0];
        alu_in.timeout = cfg.timeout_ms;
    end

    tsr_alu u_alu (
        .alu_in (alu_in),
        .hit    (alu_hit)
    );

    assign out_free   = !out_vld_reg || res.ready;
    assign issue      = (rd_idx_reg < count_reg);
    assign walk_done  = !chk_vld_reg && !issue;
    assign join_limit = (cfg.max_devices < DEPTH_LIM) ? cfg.max_devices : DEPTH_LIM;
    assign emit_last  = ((rd_idx_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        changed_next   = changed_reg;
        version_next   = version_reg;
        slots_next     = slots_reg;
        dev_next       = dev_reg;
        join_next      = join_reg;
        now_next       = now_reg;
        out_vld_next   = out_vld_reg;
        out_dev_next   = out_dev_reg;
        out_chan_next  = out_chan_reg;
        out_slot_next  = out_slot_reg;
        out_total_next = out_total_reg;
        out_ver_next   = out_ver_reg;
        out_rej_next   = out_rej_reg;
        out_last_next  = out_last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = chk_idx_reg;
        ram_wr_data    = {dev_reg, now_reg};
        ram_rd_en      = 1'b0;
        ram_rd_addr    = rd_idx_reg[IDX_W-1:0];
        emit_go        = 1'b0;
        emit_cnt       = count_reg;

        if (res.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    dev_next     = req.dev_id;
                    join_next    = req.is_join;
                    now_next     = req.now_ms;
                    rd_idx_next  = '0;
                    wr_idx_next  = '0;
                    chk_vld_next = 1'b0;
                    changed_next = 1'b0;
                    state_next   = req.req_type ? ST_EXP : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (dev_reg == cfg.broadcast_id)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // read one entry a cycle, compare it the cycle after
                    ram_rd_en    = issue;
                    chk_vld_next = issue;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                    if (chk_vld_reg && alu_hit)
                    begin
                        ram_wr_en  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (walk_done)
                    begin
                        if (!join_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (5'(count_reg) >= join_limit)
                        begin
                            state_next = ST_REJ;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = count_reg[IDX_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                            emit_go     = 1'b1;
                            emit_cnt    = count_reg + CNT_W'(1);
                        end
                    end
                end
            end

            ST_EXP:
            begin
                ram_rd_en    = issue;
                chk_vld_next = issue;
                chk_idx_next = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (chk_vld_reg)
                begin
                    if (alu_hit)
                    begin
                        changed_next = 1'b1;
                    end
                    else
                    begin
                        // survivors slide down; write index never passes read index
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wr_idx_reg[IDX_W-1:0];
                        ram_wr_data = ram_rd_data;
                        wr_idx_next = wr_idx_reg + CNT_W'(1);
                    end
                end
                else if (walk_done)
                begin
                    if (changed_reg)
                    begin
                        count_next = wr_idx_reg;
                        emit_go    = 1'b1;
                        emit_cnt   = wr_idx_reg;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_dev_next   = ram_rd_data[ENT_W-1:tsr_pkg::TIME_W];
                    out_chan_next  = cfg.channel_id;
                    out_slot_next  = 8'(rd_idx_reg);
                    out_total_next = slots_reg;
                    out_ver_next   = version_reg;
                    out_rej_next   = 1'b0;
                    out_last_next  = emit_last;
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    state_next     = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end

            ST_REJ:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_dev_next   = dev_reg;
                    out_chan_next  = cfg.channel_id;
                    out_slot_next  = tsr_pkg::REJECT_SLOT;
                    out_total_next = slots_reg;
                    out_ver_next   = version_reg;
                    out_rej_next   = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // map changed: new version, then walk the table for assignments unless it is now empty
        if (emit_go)
        begin
            version_next = version_reg + 8'd1;
            slots_next   = (emit_cnt == '0) ? 5'd1 : 5'(emit_cnt);
            rd_idx_next  = '0;
            state_next   = (emit_cnt == '0) ? ST_IDLE : ST_EMIT_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
            version_reg <= 8'd0;
            slots_reg   <= 5'd1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            version_reg <= version_next;
            slots_reg   <= slots_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        wr_idx_reg    <= wr_idx_next;
        chk_idx_reg   <= chk_idx_next;
        changed_reg   <= changed_next;
        dev_reg       <= dev_next;
        join_reg      <= join_next;
        now_reg       <= now_next;
        out_dev_reg   <= out_dev_next;
        out_chan_reg  <= out_chan_next;
        out_slot_reg  <= out_slot_next;
        out_total_reg <= out_total_next;
        out_ver_reg   <= out_ver_next;
        out_rej_reg   <= out_rej_next;
        out_last_reg  <= out_last_next;
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign res.valid          = out_vld_reg;
    assign res.target_dev     = out_dev_reg;
    assign res.assign_channel = out_chan_reg;
    assign res.slot_index     = out_slot_reg;
    assign res.slot_total     = out_total_reg;
    assign res.map_version    = out_ver_reg;
    assign res.rejected       = out_rej_reg;
    assign res.last           = out_last_reg;

endmodule

// ===== sv/tdma_slot_registry.sv =====
// Channel  Dir  Handshake        Payload
// req      in   valid/ready      req_type, dev_id, is_join, now_ms
// res      out  valid/ready      target_dev, assign_channel, slot_index, slot_total,
//                                map_version, rejected, last
// apb      in   psel/penable     channel_id, max_devices, timeout_ms, broadcast_id
//
// One item at a time; the table walk, one entry a cycle through the entry RAM, sets the pace.
// Uplink: searches the n entries, then on a join reads out and emits each assignment.
// Tick: ages and compacts the n entries, then on a change reads out and emits each assignment.
// req.ready is high only when idle; a waiting result does not hold off the next item.
// res stalls hold the walk in place. No clearing pass after reset.
module tdma_slot_registry #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tsr_req_if.sink     req,
    tsr_res_if.source   res
);
    logic [7:0]  channel_id_reg;
    logic [4:0]  max_devices_reg;
    logic [31:0] timeout_ms_reg;
    logic [7:0]  broadcast_id_reg;
    logic        wr_stb;

    tsr_pkg::tsr_cfg_t cfg;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_id_reg   <= tsr_pkg::RST_CHANNEL_ID;
            max_devices_reg  <= tsr_pkg::RST_MAX_DEVICES;
            timeout_ms_reg   <= tsr_pkg::RST_TIMEOUT_MS;
            broadcast_id_reg <= tsr_pkg::RST_BROADCAST_ID;
        end
        else if (wr_stb)
        begin
            case (paddr)
                tsr_pkg::ADDR_CHANNEL_ID:   channel_id_reg   <= pwdata[7:0];
                tsr_pkg::ADDR_MAX_DEVICES:  max_devices_reg  <= pwdata[4:0];
                tsr_pkg::ADDR_TIMEOUT_MS:   timeout_ms_reg   <= pwdata;
                tsr_pkg::ADDR_BROADCAST_ID: broadcast_id_reg <= pwdata[7:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            tsr_pkg::ADDR_CHANNEL_ID:   prdata = {24'd0, channel_id_reg};
            tsr_pkg::ADDR_MAX_DEVICES:  prdata = {27'd0, max_devices_reg};
            tsr_pkg::ADDR_TIMEOUT_MS:   prdata = timeout_ms_reg;
            tsr_pkg::ADDR_BROADCAST_ID: prdata = {24'd0, broadcast_id_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.channel_id   = channel_id_reg;
        cfg.max_devices  = max_devices_reg;
        cfg.timeout_ms   = timeout_ms_reg;
        cfg.broadcast_id = broadcast_id_reg;
    end

    tsr_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );

endmodule

// ===== sv/tsr_checker.sv =====
module tsr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] target_dev,
    input logic [7:0] slot_index,
    input logic [4:0] slot_total,
    input logic [7:0] map_version,
    input logic       rejected,
    input logic       last
);

    // a stalled item keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(target_dev)
            && $stable(slot_index) && $stable(map_version) && $stable(last))
        else $error("res item changed while stalled");

    // an accepted item keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted back to back");

    // a refusal is a single item with the reject slot
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && rejected |-> last && slot_index == 8'hFF)
        else $error("reject item malformed");

    // a real assignment always lies inside the superframe
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !rejected |-> {3'd0, slot_total} > slot_index)
        else $error("slot outside superframe");

endmodule

bind tdma_slot_registry tsr_checker u_tsr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .target_dev  (res.target_dev),
    .slot_index  (res.slot_index),
    .slot_total  (res.slot_total),
    .map_version (res.map_version),
    .rejected    (res.rejected),
    .last        (res.last)
);

// ===== dv/tsr_test_pkg.sv =====
`timescale 1ns / 1ps
package tsr_test_pkg;

    // request kinds on the req channel
    localparam logic REQ_UPLINK = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef struct packed {
        logic [7:0] target_dev;
        logic [7:0] channel;
        logic [7:0] slot;
        logic [4:0] total;
        logic [7:0] version;
        logic       rejected;
        logic       last;
    } slot_assign_t;

endpackage

// ===== dv/tsr_slot_checker.sv =====
`timescale 1ns / 1ps
module tsr_slot_checker
    import tsr_pkg::*;
    import tsr_test_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    tsr_req_if          req,
    tsr_res_if          res,
    output int          mismatches,
    output int          awaiting,
    output int          reqs_seen,
    output int          assigns_seen,
    output int          refusals_seen,
    output int          expiries_seen
);

    logic [7:0]  chan_q;
    logic [4:0]  maxdev_q;
    logic [31:0] tmo_q;
    logic [7:0]  bcast_q;

    logic [7:0]  dev_tab  [TABLE_DEPTH];
    logic [31:0] seen_tab [TABLE_DEPTH];
    int unsigned dev_cnt;
    logic [7:0]  map_ver;
    logic [4:0]  slots_q;

    slot_assign_t due_q [$];
    int errs, n_reqs, n_assigns, n_refusals, n_expiries;

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
            errs++;
        end
    endtask

    // new map: version bump, then one assignment per table position
    task automatic publish_map();
        slot_assign_t a;
        map_ver++;
        slots_q = (dev_cnt > 0) ? 5'(dev_cnt) : 5'd1;
        for (int i = 0; i < dev_cnt; i++) begin
            a.target_dev = dev_tab[i];
            a.channel    = chan_q;
            a.slot       = 8'(i);
            a.total      = slots_q;
            a.version    = map_ver;
            a.rejected   = 1'b0;
            a.last       = (i + 1 == dev_cnt);
            due_q.push_back(a);
        end
    endtask

    task automatic predict_item(logic rt, logic [7:0] id, logic j, logic [31:0] now);
        slot_assign_t a;
        int unsigned keep, limit;
        bit dropped;
        n_reqs++;
        if (rt == REQ_UPLINK) begin
            if (id == bcast_q)
                return;
            for (int i = 0; i < dev_cnt; i++) begin
                if (dev_tab[i] == id) begin
                    seen_tab[i] = now;
                    return;
                end
            end
            if (!j)
                return;
            limit = (maxdev_q < TABLE_DEPTH) ? maxdev_q : TABLE_DEPTH;
            if (dev_cnt >= limit) begin
                a.target_dev = id;
                a.channel    = chan_q;
                a.slot       = REJECT_SLOT;
                a.total      = slots_q;
                a.version    = map_ver;
                a.rejected   = 1'b1;
                a.last       = 1'b1;
                due_q.push_back(a);
                return;
            end
            dev_tab[dev_cnt]  = id;
            seen_tab[dev_cnt] = now;
            dev_cnt++;
            publish_map();
        end else begin
            keep    = 0;
            dropped = 1'b0;
            for (int i = 0; i < dev_cnt; i++) begin
                if (32'(now - seen_tab[i]) > tmo_q) begin
                    dropped = 1'b1;
                end else begin
                    dev_tab[keep]  = dev_tab[i];
                    seen_tab[keep] = seen_tab[i];
                    keep++;
                end
            end
            if (dropped) begin
                dev_cnt = keep;
                n_expiries++;
                publish_map();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        slot_assign_t want;
        if (!rst_n) begin
            chan_q     = RST_CHANNEL_ID;
            maxdev_q   = RST_MAX_DEVICES;
            tmo_q      = RST_TIMEOUT_MS;
            bcast_q    = RST_BROADCAST_ID;
            dev_cnt    = 0;
            map_ver    = 8'd0;
            slots_q    = 5'd1;
            errs       = 0;
            n_reqs     = 0;
            n_assigns  = 0;
            n_refusals = 0;
            n_expiries = 0;
            due_q.delete();
        end else begin
            if (res.valid && res.ready) begin
                n_assigns++;
                if (res.rejected)
                    n_refusals++;
                if (due_q.size() == 0) begin
                    $display("%0t ns: assignment to 0x%0h arrived, expected none, actual slot 0x%0h",
                             $time, res.target_dev, res.slot_index);
                    errs++;
                end else begin
                    want = due_q.pop_front();
                    check_field("target_dev", want.target_dev, res.target_dev);
                    check_field("assign_channel", want.channel, res.assign_channel);
                    check_field("slot_index", want.slot, res.slot_index);
                    check_field("slot_total", want.total, res.slot_total);
                    check_field("map_version", want.version, res.map_version);
                    check_field("rejected", want.rejected, res.rejected);
                    check_field("last", want.last, res.last);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_CHANNEL_ID:   chan_q   = pwdata[7:0];
                    ADDR_MAX_DEVICES:  maxdev_q = pwdata[4:0];
                    ADDR_TIMEOUT_MS:   tmo_q    = pwdata;
                    ADDR_BROADCAST_ID: bcast_q  = pwdata[7:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                predict_item(req.req_type, req.dev_id, req.is_join, req.now_ms);
        end
        mismatches    <= errs;
        awaiting      <= due_q.size();
        reqs_seen     <= n_reqs;
        assigns_seen  <= n_assigns;
        refusals_seen <= n_refusals;
        expiries_seen <= n_expiries;
    end

endmodule

// ===== dv/tdma_slot_registry_test.sv =====
`timescale 1ns / 1ps
module tdma_slot_registry_test;
    import tsr_pkg::*;
    import tsr_test_pkg::*;

    localparam int TABLE_DEPTH = 16;
    // worst table walk with a full map, plus margin
    localparam int IDLE_SETTLE = 2 * TABLE_DEPTH + 30;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tsr_req_if req_ch ();
    tsr_res_if res_ch ();

    int mismatches, awaiting, reqs_seen, assigns_seen, refusals_seen, expiries_seen;

    logic [31:0] cur_ms;
    logic [31:0] tmo_cur;
    logic [7:0]  bcast_cur;
    logic [7:0]  pool_base;
    int unsigned stall_left = 0;

    always #2 clk = ~clk;

    tdma_slot_registry #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    tsr_slot_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .req           (req_ch),
        .res           (res_ch),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .reqs_seen     (reqs_seen),
        .assigns_seen  (assigns_seen),
        .refusals_seen (refusals_seen),
        .expiries_seen (expiries_seen)
    );

    // receiver: short stalls, now and then a long stretch with no back-pressure
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (res_ch.ready) begin
            res_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 7);
        end else begin
            res_ch.ready <= 1'b1;
            stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(0, 5);
        end
    end

    task automatic write_reg(logic [3:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // leaves valid high so a burst can follow on the next item
    task automatic send_item(logic rt, logic [7:0] id, logic j, logic [31:0] now);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.dev_id   <= id;
        req_ch.is_join  <= j;
        req_ch.now_ms   <= now;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic drain(int unsigned settle);
        @(posedge clk);
        wait (awaiting == 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic random_item(output bit counted);
        int unsigned pick;
        logic [7:0] id;
        longint unsigned span;
        pick = $urandom_range(0, 99);
        id   = pool_base + 8'($urandom_range(0, 23));
        span = (tmo_cur == 0) ? 64'd8 : 64'(tmo_cur);
        if ($urandom_range(0, 19) == 0)
            cur_ms = $urandom();
        else if ($urandom_range(0, 11) == 0)
            cur_ms += 32'(span + $urandom_range(0, 32'(span >> 1)));
        else
            cur_ms += $urandom_range(0, 32'(span >> 3));
        counted = 1'b1;
        if (pick < 25) begin
            send_item(REQ_TICK, 8'($urandom()), 1'($urandom()), cur_ms);
        end else if (pick < 30) begin
            send_item(REQ_UPLINK, bcast_cur, 1'($urandom()), cur_ms);
            counted = 1'b0;
        end else if (pick < 35) begin
            send_item(REQ_UPLINK, 8'($urandom()), 1'($urandom()), cur_ms);
        end else begin
            send_item(REQ_UPLINK, id, pick < 75, cur_ms);
        end
    endtask

    task automatic run_random(int unsigned quota);
        int unsigned done_n, burst;
        bit counted;
        done_n = 0;
        while (done_n < quota) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
            while (burst > 0 && done_n < quota) begin
                random_item(counted);
                if (counted)
                    done_n++;
                burst--;
            end
            req_ch.valid <= 1'b0;
            if ($urandom_range(0, 24) == 0)
                drain(1);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(logic [7:0] chan, logic [4:0] maxd, logic [31:0] tmo,
                             logic [7:0] bcast, int unsigned quota);
        drain(IDLE_SETTLE);
        write_reg(ADDR_CHANNEL_ID, 32'(chan));
        write_reg(ADDR_MAX_DEVICES, 32'(maxd));
        write_reg(ADDR_TIMEOUT_MS, tmo);
        write_reg(ADDR_BROADCAST_ID, 32'(bcast));
        tmo_cur   = tmo;
        bcast_cur = bcast;
        run_random(quota);
    endtask

    initial begin
        logic [31:0] t0;
        t0              = 32'hFFFF_FF00;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_UPLINK;
        req_ch.dev_id   = '0;
        req_ch.is_join  = 1'b0;
        req_ch.now_ms   = '0;
        res_ch.ready    = 1'b0;
        tmo_cur         = RST_TIMEOUT_MS;
        bcast_cur       = RST_BROADCAST_ID;
        pool_base       = 8'h20;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset register values; times wrap through zero
        send_item(REQ_TICK, 8'h00, 1'b0, t0);
        send_item(REQ_UPLINK, 8'h10, 1'b0, t0);
        send_item(REQ_UPLINK, RST_BROADCAST_ID, 1'b1, t0);
        send_item(REQ_UPLINK, 8'h00, 1'b1, t0);
        send_item(REQ_UPLINK, 8'h10, 1'b1, t0 + 32'd10);
        send_item(REQ_UPLINK, 8'h00, 1'b1, t0 + 32'd20);
        send_item(REQ_UPLINK, 8'h10, 1'b0, t0 + 32'd30);
        // silence of exactly the timeout keeps the device
        send_item(REQ_TICK, 8'hFF, 1'b1, t0 + 32'd30020);
        for (int k = 1; k <= 14; k++)
            send_item(REQ_UPLINK, 8'(k), 1'b1, t0 + 32'd30100);
        send_item(REQ_UPLINK, 8'hFE, 1'b1, t0 + 32'd30100);
        send_item(REQ_UPLINK, 8'h10, 1'b0, t0 + 32'd60000);
        // head of the table expires, the rest shifts down
        send_item(REQ_TICK, 8'h00, 1'b0, t0 + 32'd60030);
        send_item(REQ_TICK, 8'h00, 1'b0, t0 + 32'd100000);
        req_ch.valid <= 1'b0;
        cur_ms = t0 + 32'd100000;

        pool_base = 8'hF0;
        run_phase(8'hFF, 5'd0, 32'hFFFF_FFFF, 8'h00, 40);
        pool_base = $urandom();
        run_phase(8'h5A, 5'd16, 32'd1000, 8'hFF, 90);
        pool_base = $urandom();
        run_phase(8'h01, 5'd31, 32'd30000, 8'h80, 90);
        pool_base = $urandom();
        run_phase(8'hA5, 5'd3, 32'd1, 8'h7F, 50);
        pool_base = $urandom();
        run_phase(8'h3C, 5'd5, 32'd0, 8'h01, 50);
        pool_base = $urandom();
        // broadcast id inside the device pool, so some registered ids go quiet
        run_phase(8'($urandom()), 5'($urandom_range(0, 31)), $urandom_range(1, 100000),
                  pool_base + 8'd5, 110);

        drain(IDLE_SETTLE);
        $display("Run covered %0d requests over reset values and six register settings,",
                 reqs_seen);
        $display("  %0d slot assignments checked, %0d refused joins, %0d expiring scans.",
                 assigns_seen, refusals_seen, expiries_seen);
        if (mismatches == 0 && awaiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tsr_pkg.sv
sv/tsr_if.sv
sv/tsr_ram.sv
sv/tsr_alu.sv
sv/tsr_ctrl.sv
sv/tdma_slot_registry.sv
sv/tsr_checker.sv
dv/tsr_test_pkg.sv
dv/tsr_slot_checker.sv
dv/tdma_slot_registry_test.sv
